// File: sv/hebp_pkg.sv
// hebp_pkg: types and constants shared by the huffman encode bit packer
// no dependencies
package hebp_pkg;

  localparam int CODE_W = 32;          // code field of one table entry
  localparam int LEN_W  = 6;           // code length field
  localparam int ACC_W  = CODE_W + 7;  // pending bits plus the longest code
  localparam int TOT_W  = 6;           // bit count in the accumulator
  localparam int QDEPTH = 4;           // front to back queue depth
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // one table entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } code_t;

  // one job for the packer
  typedef struct packed {
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

// File: sv/hebp_front.sv
// hebp_front: accepts items, keeps the code table and issues packer jobs
// depends on hebp_pkg
module hebp_front
  import hebp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOLS      = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        symbol_i,
  input  logic [5:0]        code_len_i,
  input  logic [31:0]       code_bits_i,
  input  logic [QCNT_W-1:0] qcount_i,
  output logic              full_o,
  output logic              qpush_o,
  output entry_t            qdata_o
);

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  code_t mem [SYMBOLS];
  code_t rd_q;
  logic  s1_v_q, s1_v_d;
  logic  s1_flush_q, s1_flush_d;

  logic              accept;
  logic              in_range;
  logic              wr_en, rd_en;
  logic [LEN_W-1:0]  len_lim;
  logic [CODE_W:0]   mask_w;
  logic [QCNT_W:0]   occ;
  logic [SYM_W-1:0]  idx;
  op_e               op;

  assign accept   = push_i && !full_o;
  assign in_range = {1'b0, symbol_i} < 9'(SYMBOLS);
  assign idx      = symbol_i[SYM_W-1:0];
  assign op       = op_e'(op_i);

  // credit check: the stage register may still push one job
  assign occ    = {1'b0, qcount_i} + {{QCNT_W{1'b0}}, s1_v_q};
  assign full_o = occ >= (QCNT_W+1)'(QDEPTH);

  assign len_lim = (code_len_i > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_len_i;
  assign mask_w  = ({{CODE_W{1'b0}}, 1'b1} << len_lim) - {{CODE_W{1'b0}}, 1'b1};

  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s1_v_d     = 1'b0;
    s1_flush_d = 1'b0;
    if (accept) begin
      unique case (op)
        OP_LOAD: begin
          wr_en = in_range;
        end
        OP_ENCODE: begin
          rd_en  = in_range;
          s1_v_d = in_range;
        end
        OP_FLUSH: begin
          s1_v_d     = 1'b1;
          s1_flush_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // code table, masked bits stored at load time
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx] <= '{len: len_lim, code: code_bits_i & mask_w[CODE_W-1:0]};
    end
    if (rd_en) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      s1_v_q     <= s1_v_d;
      s1_flush_q <= s1_flush_d;
    end
  end

  // empty codes never reach the packer
  assign qpush_o = s1_v_q && (s1_flush_q || (rd_q.len != '0));
  assign qdata_o = '{flush: s1_flush_q, len: rd_q.len, code: rd_q.code};

endmodule

// File: sv/hebp_queue.sv
// hebp_queue: short job queue between the front and the packer
// depends on hebp_pkg
module hebp_queue
  import hebp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  entry_t            data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output entry_t            data_o,
  output logic [QCNT_W-1:0] count_o
);

  entry_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rptr_q];
  assign count_o = cnt_q;
  assign do_push = push_i && (cnt_q != QCNT_W'(QDEPTH));
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: sv/hebp_back.sv
// hebp_back: bit accumulator that packs codes into bytes, with output register
// depends on hebp_pkg
module hebp_back
  import hebp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_v_i,
  input  entry_t     head_i,
  output logic       head_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  back_state_e       state_q, state_d;
  logic [ACC_W-1:0]  acc_q;
  logic [TOT_W-1:0]  tot_q;
  logic [6:0]        pend_q, pend_d;
  logic [2:0]        pcnt_q, pcnt_d;
  logic              out_v_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;

  logic              out_rdy;
  logic [ACC_W-1:0]  src_acc;
  logic [TOT_W-1:0]  src_tot;
  logic [TOT_W-1:0]  rem;
  logic [ACC_W-1:0]  shifted;
  logic [7:0]        flush_byte;
  logic              emit, emit_last, emit_flush, load_work, upd_pend;
  logic [2:0]        keep;
  logic [7:0]        pmask;

  assign out_rdy = !out_v_q || pop_i;

  // working value: the held accumulator, or a fresh one from the queue head
  always_comb begin
    if (state_q == BK_EMIT) begin
      src_acc = acc_q;
      src_tot = tot_q;
    end else begin
      src_acc = (ACC_W'(pend_q) << head_i.len) | ACC_W'(head_i.code);
      src_tot = TOT_W'(pcnt_q) + TOT_W'(head_i.len);
    end
  end

  assign rem        = src_tot - TOT_W'(8);
  assign shifted    = src_acc >> rem;
  assign flush_byte = 8'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_v_i && !head_i.flush && (src_tot >= TOT_W'(8)) && out_rdy &&
            (rem >= TOT_W'(8))) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_rdy && (rem < TOT_W'(8))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    head_pop_o = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_flush = 1'b0;
    load_work  = 1'b0;
    upd_pend   = 1'b0;
    keep       = rem[2:0];
    unique case (state_q)
      BK_IDLE: begin
        if (head_v_i) begin
          if (head_i.flush) begin
            if (pcnt_q == '0) begin
              head_pop_o = 1'b1;
            end else if (out_rdy) begin
              head_pop_o = 1'b1;
              emit       = 1'b1;
              emit_last  = 1'b1;
              emit_flush = 1'b1;
              upd_pend   = 1'b1;
              keep       = 3'd0;
            end
          end else if (src_tot < TOT_W'(8)) begin
            head_pop_o = 1'b1;
            upd_pend   = 1'b1;
            keep       = src_tot[2:0];
          end else if (out_rdy) begin
            head_pop_o = 1'b1;
            emit       = 1'b1;
            if (rem < TOT_W'(8)) begin
              emit_last = 1'b1;
              upd_pend  = 1'b1;
            end else begin
              load_work = 1'b1;
            end
          end
        end
      end
      BK_EMIT: begin
        if (out_rdy) begin
          emit = 1'b1;
          if (rem < TOT_W'(8)) begin
            emit_last = 1'b1;
            upd_pend  = 1'b1;
          end else begin
            load_work = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign pmask  = (8'd1 << keep) - 8'd1;
  assign pend_d = upd_pend ? (src_acc[6:0] & pmask[6:0]) : pend_q;
  assign pcnt_d = upd_pend ? keep : pcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      pend_q  <= '0;
      pcnt_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_work) begin
      acc_q <= src_acc;
      tot_q <= rem;
    end
    if (emit) begin
      out_byte_q <= emit_flush ? flush_byte : shifted[7:0];
      out_last_q <= emit_last;
    end
  end

  assign empty_o    = !out_v_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = out_last_q;

endmodule

// File: sv/huffman_encode_bit_packer.sv
// huffman_encode_bit_packer: top level of the huffman encode bit packer
// depends on hebp_pkg, hebp_front, hebp_queue, hebp_back
//
// input channel: push / full, an item is taken at a clock edge with push high
//   and full low. op selects load table entry, encode byte or flush.
// result channel: empty / pop, out_byte_o and last_o show the oldest byte
//   while empty is low; it leaves at an edge with pop high and empty low.
// path: an item passes the table read register and the queue, then the packer
//   writes its first byte into the output register.
// throughput: one item per cycle enters while full is low; the packer gives one
//   byte per cycle while the receiver takes them, and an encode item gives at most
//   4 bytes at 32-bit codes.
// when the receiver stalls the output register holds, the packer waits and
//   the 4-deep job queue fills; full rises once the queue is out of credit.
// reset clears the queue, the stage register, the pending bits and the
//   output register; the code table is not cleared and entries must be
//   loaded before use, so there is no clearing pass
module huffman_encode_bit_packer
  import hebp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOLS      = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  symbol_i,
  input  logic [5:0]  code_len_i,
  input  logic [31:0] code_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  // front to queue
  logic              qpush;
  entry_t            qdata;
  logic [QCNT_W-1:0] qcount;

  // queue to packer
  logic              head_v;
  entry_t            head;
  logic              head_pop;

  // front: table writes and reads, job issue with credit check
  hebp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOLS      (SYMBOLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .op_i        (op_i),
    .symbol_i    (symbol_i),
    .code_len_i  (code_len_i),
    .code_bits_i (code_bits_i),
    .qcount_i    (qcount),
    .full_o      (full),
    .qpush_o     (qpush),
    .qdata_o     (qdata)
  );

  // decoupling queue
  hebp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qpush),
    .data_i  (qdata),
    .pop_i   (head_pop),
    .valid_o (head_v),
    .data_o  (head),
    .count_o (qcount)
  );

  // back: bit packing and the output register
  hebp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_v_i   (head_v),
    .head_i     (head),
    .head_pop_o (head_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

// File: sv/hebp_checker.sv
// hebp_checker: port level checks for the huffman encode bit packer
// depends on huffman_encode_bit_packer, bound to it below
module hebp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [1:0]  op_i,
  input logic [7:0]  symbol_i,
  input logic [5:0]  code_len_i,
  input logic [31:0] code_bits_i,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte_o,
  input logic        last_o
);

  // leaving reset the block is empty and ready
  a_reset_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("not empty and ready after reset");

  // a waiting byte holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_o)))
    else $error("result changed while stalled");

  // bytes of one item follow back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a multi-byte item");

endmodule

bind huffman_encode_bit_packer hebp_checker u_hebp_checker (.*);

// File: verif/huffman_encode_bit_packer_checker.sv
`timescale 1ns / 100ps
// huffman_encode_bit_packer_checker: watches both queue channels of the bit packer,
// predicts the packed bytes and compares them; depends on hebp_pkg
module huffman_encode_bit_packer_checker
  import hebp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOLS      = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  symbol_i,
  input  logic [5:0]  code_len_i,
  input  logic [31:0] code_bits_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          expected_left_o
);

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packed_byte_t;

  code_t        code_table [SYMBOLS];
  logic [6:0]   held_bits  = '0;
  logic [2:0]   held_count = '0;
  packed_byte_t expected_bytes [$];
  int           fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch, %s", $time, what);
    fails++;
  endtask

  // table write, code append or flush of the leftover bits
  task automatic pack_item(input logic [1:0] op, input logic [7:0] sym,
                           input logic [5:0] len_in, input logic [31:0] bits_in);
    logic [ACC_W-1:0] acc;
    int               len;
    int               total;
    packed_byte_t     b;
    case (op)
      OP_LOAD: begin
        if (sym < SYMBOLS) begin
          code_table[sym].len  = (len_in > LEN_CAP) ? LEN_W'(LEN_CAP) : len_in;
          code_table[sym].code = bits_in;
        end
      end
      OP_ENCODE: begin
        if (sym < SYMBOLS && code_table[sym].len != 0) begin
          len   = code_table[sym].len;
          acc   = (ACC_W'(held_bits) << len)
                | (ACC_W'(code_table[sym].code) & ((ACC_W'(1) << len) - 1));
          total = held_count + len;
          while (total >= 8) begin
            total  -= 8;
            b.value = acc[total +: 8];
            b.last  = (total < 8);
            expected_bytes = {expected_bytes, b};
          end
          held_bits  = 7'(acc & ((ACC_W'(1) << total) - 1));
          held_count = 3'(total);
        end
      end
      OP_FLUSH: begin
        if (held_count != 0) begin
          b.value = 8'({1'b0, held_bits} << (8 - held_count));
          b.last  = 1'b1;
          expected_bytes = {expected_bytes, b};
          held_bits  = '0;
          held_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                    out_byte_i, last_i));
        end else begin
          want = expected_bytes[0];
          expected_bytes.delete(0);
          if (out_byte_i !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_i, want.value));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                      last_i, want.last, want.value));
        end
      end
      if (push_i && !full_i)
        pack_item(op_i, symbol_i, code_len_i, code_bits_i);
    end
    expected_left_o <= expected_bytes.size();
  end

endmodule

// File: verif/huffman_encode_bit_packer_test.sv
`timescale 1ns / 100ps
// huffman_encode_bit_packer_test: stimulus and verdict for the huffman bit packer
// depends on hebp_pkg, huffman_encode_bit_packer and huffman_encode_bit_packer_checker
module huffman_encode_bit_packer_test;
  import hebp_pkg::*;

  // op code 3 has no meaning, the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 200;
  localparam int QUIET_FROM   = 165;  // no idling on either side from here on

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op = '0;
  logic [7:0]  symbol = '0;
  logic [5:0]  code_len = '0;
  logic [31:0] code_bits = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  int          fail_count;
  int          expected_left;
  bit          quiet = 1'b0;

  // which table entries hold a code; encoding an unwritten entry is never sent
  bit          loaded [256];
  logic [7:0]  loaded_syms [$];

  huffman_encode_bit_packer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op),
    .symbol_i    (symbol),
    .code_len_i  (code_len),
    .code_bits_i (code_bits),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte),
    .last_o      (last)
  );

  huffman_encode_bit_packer_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .op_i            (op),
    .symbol_i        (symbol),
    .code_len_i      (code_len),
    .code_bits_i     (code_bits),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_byte_i      (out_byte),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: pops at every cycle but during random stall bursts,
  // exactly one assignment to pop per falling edge
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // present one item at a falling edge and hold it until a rising edge takes it;
  // push stays high so the next item can follow without a gap
  task automatic send_item(input logic [1:0] op_v, input logic [7:0] sym_v,
                           input logic [5:0] len_v, input logic [31:0] bits_v);
    @(negedge clk_i);
    push      <= 1'b1;
    op        <= op_v;
    symbol    <= sym_v;
    code_len  <= len_v;
    code_bits <= bits_v;
    do @(posedge clk_i); while (full);
  endtask

  // sender gap with push low
  task automatic idle_for(input int n);
    @(negedge clk_i);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // table write that also records the entry as usable for encode items
  task automatic load_entry(input logic [7:0] sym_v, input logic [5:0] len_v,
                            input logic [31:0] bits_v);
    if (!loaded[sym_v]) begin
      loaded[sym_v] = 1'b1;
      loaded_syms = {loaded_syms, sym_v};
    end
    send_item(OP_LOAD, sym_v, len_v, bits_v);
  endtask

  // encode with junk in the fields that an encode item ignores
  task automatic encode_sym(input logic [7:0] sym_v);
    send_item(OP_ENCODE, sym_v, 6'($urandom), $urandom);
  endtask

  // mostly short codes, some long ones, a few empty and a few beyond the cap
  function automatic logic [5:0] random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return 6'd0;
    if (r < 50) return 6'($urandom_range(1, 8));
    if (r < 80) return 6'($urandom_range(9, 24));
    if (r < 94) return 6'($urandom_range(25, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  initial begin
    int n;
    int pick;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    send_item(OP_FLUSH, 8'hff, 6'h3f, 32'hffff_ffff);   // flush with no pending bits
    send_item(OP_UNUSED, 8'hff, 6'h3f, 32'hffff_ffff);  // unused op
    load_entry(8'd0,   6'd1,  32'h0000_0001);           // shortest code
    load_entry(8'd255, 6'd32, 32'hffff_ffff);           // longest code, top symbol
    load_entry(8'd1,   6'd0,  32'hffff_ffff);           // empty code
    load_entry(8'd2,   6'd63, 32'ha5a5_a5a5);           // length beyond the cap
    load_entry(8'd3,   6'd5,  32'hffff_ffe5);           // junk above the code length
    load_entry(8'd4,   6'd7,  32'h0000_0000);
    load_entry(8'd5,   6'd33, 32'h5a5a_5a5a);           // one past the cap
    encode_sym(8'd1);                                    // empty code emits nothing
    encode_sym(8'd0);
    encode_sym(8'd3);
    encode_sym(8'd4);                                    // crosses one byte boundary
    send_item(OP_FLUSH, 8'h00, 6'h00, 32'h0);
    encode_sym(8'd255);                                  // four bytes from aligned start
    encode_sym(8'd2);
    encode_sym(8'd4);
    encode_sym(8'd0);                                    // lands exactly on a byte
    send_item(OP_FLUSH, 8'h00, 6'h00, 32'h0);           // nothing pending after that
    encode_sym(8'd3);
    encode_sym(8'd255);                                  // four bytes with bits left over
    encode_sym(8'd5);
    send_item(OP_FLUSH, 8'h00, 6'h00, 32'h0);
    send_item(OP_UNUSED, 8'h00, 6'h00, 32'h0);

    // random part: loads keep the table changing, encodes dominate
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n >= QUIET_FROM)
        quiet = 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0)
        idle_for($urandom_range(1, 16));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        load_entry(8'($urandom), random_len(), $urandom);
        n++;
      end else if (pick < 82) begin
        encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        n++;
      end else if (pick < 96) begin
        send_item(OP_FLUSH, 8'($urandom), 6'($urandom), $urandom);
        n++;
      end else begin
        send_item(OP_UNUSED, 8'($urandom), 6'($urandom), $urandom);
      end
    end
    send_item(OP_FLUSH, 8'h00, 6'h00, 32'h0);

    // drain: wait for every expected byte, then wait on for any stray ones
    @(negedge clk_i);
    push <= 1'b0;
    @(negedge clk_i);
    while (expected_left != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (fail_count == 0 && expected_left == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
